[src/mntp_pkg.sv]
package mntp_pkg;

  // Event queue geometry.
  localparam int unsigned EvqDepth = 4;
  localparam int unsigned EvqAw    = 2;
  localparam int unsigned EvqCw    = 3;

  // One character of note text with its end-of-argument flag.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  // One note or rest event.
  typedef struct packed {
    logic       is_rest;
    logic [3:0] semitone;
    logic [3:0] octave;
    logic [6:0] duration_denominator;
    logic       dotted;
    logic       last_of_run;
  } out_t;

  // Everything one character produces: zero, one or two events.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       ev0;
    out_t       ev1;
  } mntp_res_t;

endpackage

[src/mntp_parser.sv]
module mntp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  mntp_pkg::in_t       item_i,
  output mntp_pkg::mntp_res_t res_o
);

  localparam logic [2:0] ModeIdle   = 3'd0;
  localparam logic [2:0] ModeDigits = 3'd1;
  localparam logic [2:0] ModePitch  = 3'd2;
  localparam logic [2:0] ModeSharp  = 3'd3;
  localparam logic [2:0] ModeOctave = 3'd4;
  localparam logic [2:0] ModeRest   = 3'd5;

  localparam logic [6:0] DurMax     = 7'd64;
  localparam logic [6:0] DurDefault = 7'd4;
  localparam logic [3:0] OctDefault = 4'd4;
  localparam logic [3:0] SemiE      = 4'd4;
  localparam logic [3:0] SemiB      = 4'd11;

  localparam logic [7:0] ChSharp  = 8'h23; // '#'
  localparam logic [7:0] ChSharpS = 8'h53; // 'S'
  localparam logic [7:0] ChDot    = 8'h2E; // '.'
  localparam logic [7:0] ChZero   = 8'h30; // '0'
  localparam logic [7:0] ChNine   = 8'h39; // '9'
  localparam logic [7:0] ChRestU  = 8'h52; // 'R'
  localparam logic [7:0] ChRestL  = 8'h72; // 'r'

  logic [2:0] mode_q, mode_d;
  logic [6:0] acc_q, acc_d;
  logic [3:0] semi_q, semi_d;
  logic [3:0] oct_q, oct_d;
  logic       rest_q, rest_d;

  // Builds an event from the pending note; duration is clamped to 1..64.
  function automatic mntp_pkg::out_t mk_event(logic rest, logic [3:0] semi,
                                              logic [3:0] oct, logic [6:0] acc,
                                              logic dot);
    mntp_pkg::out_t e;
    logic [6:0]     d;
    d = (acc > DurMax) ? DurMax : acc;
    if (d == 7'd0) begin
      d = 7'd1;
    end
    e.is_rest              = rest;
    e.semitone             = rest ? 4'd0 : semi;
    e.octave               = rest ? OctDefault : oct;
    e.duration_denominator = d;
    e.dotted               = dot;
    e.last_of_run          = 1'b0;
    return e;
  endfunction

  always_comb begin
    logic [7:0]     c;
    logic           is_digit;
    logic [3:0]     dv;
    logic           st_ok;
    logic [3:0]     st;
    logic           starts;
    logic           is_sharp;
    logic           do_idle;
    logic [10:0]    v;
    mntp_pkg::out_t ea, eb;
    logic           ea_v, eb_v;

    c        = item_i.char_code;
    is_digit = (c >= ChZero) && (c <= ChNine);
    dv       = c[3:0];
    is_sharp = (c == ChSharp) || (c == ChSharpS);
    st_ok    = 1'b1;
    case (c)
      8'h43:   st = 4'd0;  // C
      8'h44:   st = 4'd2;  // D
      8'h45:   st = 4'd4;  // E
      8'h46:   st = 4'd5;  // F
      8'h47:   st = 4'd7;  // G
      8'h41:   st = 4'd9;  // A
      8'h42:   st = 4'd11; // B
      default: begin
        st    = 4'd0;
        st_ok = 1'b0;
      end
    endcase
    starts = st_ok || (c == ChRestU) || (c == ChRestL);

    mode_d  = mode_q;
    acc_d   = acc_q;
    semi_d  = semi_q;
    oct_d   = oct_q;
    rest_d  = rest_q;
    ea      = '0;
    eb      = '0;
    ea_v    = 1'b0;
    eb_v    = 1'b0;
    do_idle = 1'b0;
    v       = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {7'd0, dv};

    case (mode_q)
      ModeDigits: begin
        if (is_digit) begin
          acc_d = (v > {4'd0, DurMax}) ? DurMax : v[6:0];
        end else if (starts) begin
          if ((c == ChRestU) || (c == ChRestL)) begin
            rest_d = 1'b1;
            mode_d = ModeRest;
          end else begin
            rest_d = 1'b0;
            semi_d = st;
            mode_d = ModePitch;
          end
        end else begin
          mode_d = ModeIdle;
          acc_d  = DurDefault;
          semi_d = 4'd0;
          oct_d  = OctDefault;
          rest_d = 1'b0;
        end
      end
      ModePitch, ModeSharp: begin
        if ((mode_q == ModePitch) && is_sharp) begin
          // A sharp on E or B is swallowed without changing the pitch.
          if ((semi_q != SemiE) && (semi_q != SemiB)) begin
            semi_d = semi_q + 4'd1;
          end
          mode_d = ModeSharp;
        end else if (is_digit) begin
          oct_d  = dv;
          mode_d = ModeOctave;
        end else begin
          ea      = mk_event(rest_q, semi_q, oct_q, acc_q, c == ChDot);
          ea_v    = 1'b1;
          do_idle = (c != ChDot);
          mode_d  = ModeIdle;
          acc_d   = DurDefault;
          semi_d  = 4'd0;
          oct_d   = OctDefault;
          rest_d  = 1'b0;
        end
      end
      ModeOctave, ModeRest: begin
        ea      = mk_event(rest_q, semi_q, oct_q, acc_q, c == ChDot);
        ea_v    = 1'b1;
        do_idle = (c != ChDot);
        mode_d  = ModeIdle;
        acc_d   = DurDefault;
        semi_d  = 4'd0;
        oct_d   = OctDefault;
        rest_d  = 1'b0;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Token start, also used when a closing character begins the next token.
    if (do_idle) begin
      mode_d = ModeIdle;
      acc_d  = DurDefault;
      semi_d = 4'd0;
      oct_d  = OctDefault;
      rest_d = 1'b0;
      if (is_digit) begin
        acc_d  = {3'd0, dv};
        mode_d = ModeDigits;
      end else if ((c == ChRestU) || (c == ChRestL)) begin
        rest_d = 1'b1;
        mode_d = ModeRest;
      end else if (st_ok) begin
        semi_d = st;
        mode_d = ModePitch;
      end
    end

    if (item_i.end_of_text) begin
      if ((mode_d == ModePitch) || (mode_d == ModeSharp) ||
          (mode_d == ModeOctave) || (mode_d == ModeRest)) begin
        eb   = mk_event(rest_d, semi_d, oct_d, acc_d, 1'b0);
        eb_v = 1'b1;
      end
      mode_d = ModeIdle;
      acc_d  = DurDefault;
      semi_d = 4'd0;
      oct_d  = OctDefault;
      rest_d = 1'b0;
    end

    res_o.cnt = {1'b0, ea_v} + {1'b0, eb_v};
    res_o.ev0 = ea_v ? ea : eb;
    res_o.ev0.last_of_run = !(ea_v && eb_v);
    res_o.ev1 = eb;
    res_o.ev1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q  <= DurDefault;
      semi_q <= 4'd0;
      oct_q  <= OctDefault;
      rest_q <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      semi_q <= semi_d;
      oct_q  <= oct_d;
      rest_q <= rest_d;
    end
  end

endmodule

[src/mntp_evq.sv]
module mntp_evq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  mntp_pkg::mntp_res_t            res_i,
  input  logic                           pop_i,
  output mntp_pkg::out_t                 data_o,
  output logic [mntp_pkg::EvqCw-1:0]     cnt_o
);

  mntp_pkg::out_t                mem_q [mntp_pkg::EvqDepth];
  logic [mntp_pkg::EvqAw-1:0]    wr_q, rd_q;
  logic [mntp_pkg::EvqCw-1:0]    cnt_q;
  logic [1:0]                    n_push;

  assign n_push = push_i ? res_i.cnt : 2'd0;
  assign data_o = mem_q[rd_q];
  assign cnt_o  = cnt_q;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= res_i.ev0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + 2'd1] <= res_i.ev1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + {1'b0, pop_i};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop_i};
    end
  end

endmodule

[src/music_note_text_parser_unit.sv]
// Note text parser: one character request in, zero to two note events out.
// A character is taken into the input register stage, parsed once the event
// queue has room for two events, and its events are then written into the
// queue, which offers the oldest one on the output. Throughput: one character
// per cycle while the queue has room; the single-read queue pops one event at a time.
// Reset (asynchronous, active low) empties all stages and idles the parser.
module music_note_text_parser_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mntp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mntp_pkg::out_t out_data_o
);

  // Input register stage. It holds one character request until the parser
  // can take it, which needs room for two events in the queue.
  logic                       s1_valid_q;
  mntp_pkg::in_t              s1_data_q;
  logic                       s1_fire;
  logic                       room_ok;
  mntp_pkg::mntp_res_t        res;
  logic [mntp_pkg::EvqCw-1:0] evq_cnt;
  logic                       pop;

  assign room_ok    = (evq_cnt <= mntp_pkg::EvqCw'(mntp_pkg::EvqDepth - 2));
  assign s1_fire    = s1_valid_q && room_ok;
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // The parser state advances only when the registered character is consumed;
  // all decoding and event building is a single combinational pass.
  mntp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_data_q),
    .res_o  (res)
  );

  // Events wait here so the parser keeps running while the consumer stalls.
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (evq_cnt != '0);

  mntp_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_fire),
    .res_i  (res),
    .pop_i  (pop),
    .data_o (out_data_o),
    .cnt_o  (evq_cnt)
  );

  // The queue never holds more events than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evq_cnt <= mntp_pkg::EvqCw'(mntp_pkg::EvqDepth))
    else $error("event queue overfilled");

  // A parsed character that produced events makes the output valid next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (res.cnt != 2'd0) |=> out_valid_o)
    else $error("events lost after parse");

  // With two events, only the second closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (res.cnt == 2'd2) |-> !res.ev0.last_of_run && res.ev1.last_of_run)
    else $error("bad last_of_run marking");

endmodule

[tb/tb_music_note_text_parser_unit.sv]
`timescale 1ns / 1ps

module tb_music_note_text_parser_unit;

  // Character codes that the parser treats specially.
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_SHARP = "#";
  localparam logic [7:0] CH_S     = "S";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UPPER_R = "R";
  localparam logic [7:0] CH_LOWER_R = "r";

  localparam logic [6:0] DUR_MAX     = 7'd64;
  localparam logic [6:0] DUR_DEFAULT = 7'd4;
  localparam logic [3:0] OCT_DEFAULT = 4'd4;
  localparam logic [3:0] SEMI_E      = 4'd4;
  localparam logic [3:0] SEMI_B      = 4'd11;

  // Stimulus sizing. The tail of the stream runs with no idling on either side.
  localparam int TEXT_CHARS     = 1880;
  localparam int CALM_START     = TEXT_CHARS - 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DURATION,
    ST_PITCH,
    ST_SHARP,
    ST_OCTAVE,
    ST_REST
  } note_state_e;

  // One queued character, with a flag that holds it back until every note
  // event predicted so far has come out, and a flag that allows idling.
  typedef struct {
    mntp_pkg::in_t req;
    bit            drain;
    bit            idle_ok;
  } char_slot_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid = 1'b0;
  logic           in_ready;
  mntp_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  mntp_pkg::out_t out_data;

  char_slot_t     pending_chars[$];
  mntp_pkg::out_t note_events[$];
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int unsigned    gap_cnt = 0;
  int unsigned    stall_cnt = 0;
  bit             sink_idles = 1'b1;
  string          pitch_chars = "ABCDEFGRr";

  // Parser state as the predictor sees it.
  note_state_e note_state;
  logic [6:0]  note_dur;
  logic [3:0]  note_semi;
  logic [3:0]  note_oct;
  logic        note_rest;

  music_note_text_parser_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Note event predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_note();
    note_state = ST_IDLE;
    note_dur   = DUR_DEFAULT;
    note_semi  = '0;
    note_oct   = OCT_DEFAULT;
    note_rest  = 1'b0;
  endfunction

  // Builds the event for the pending note and returns the parser to idle.
  // A rest always reports semitone 0 and the default octave.
  function automatic mntp_pkg::out_t close_note(input bit dot);
    mntp_pkg::out_t ev;
    ev.is_rest   = note_rest;
    ev.semitone  = note_rest ? 4'd0 : note_semi;
    ev.octave    = note_rest ? OCT_DEFAULT : note_oct;
    if (note_dur == 7'd0) begin
      ev.duration_denominator = 7'd1;
    end else if (note_dur > DUR_MAX) begin
      ev.duration_denominator = DUR_MAX;
    end else begin
      ev.duration_denominator = note_dur;
    end
    ev.dotted      = dot;
    ev.last_of_run = 1'b0;
    clear_note();
    return ev;
  endfunction

  // A pitch letter or a rest letter opens the body of a note.
  function automatic void open_pitch(input logic [7:0] c, input logic [3:0] semi);
    if (c == CH_UPPER_R || c == CH_LOWER_R) begin
      note_rest  = 1'b1;
      note_state = ST_REST;
    end else begin
      note_rest  = 1'b0;
      note_semi  = semi;
      note_state = ST_PITCH;
    end
  endfunction

  // Advances the predicted parser by one character and queues the events it
  // produces. A character may close the pending note and then be parsed again
  // as the start of the next token, so the state machine can run twice.
  task automatic predict_events(input mntp_pkg::in_t req);
    logic [7:0]     c;
    bit             is_digit;
    bit             starts_pitch;
    bit             again;
    int             semi;
    int             acc;
    int             n;
    mntp_pkg::out_t evs[2];
    c        = req.char_code;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (c)
      "C":     semi = 0;
      "D":     semi = 2;
      "E":     semi = 4;
      "F":     semi = 5;
      "G":     semi = 7;
      "A":     semi = 9;
      "B":     semi = 11;
      default: semi = -1;
    endcase
    starts_pitch = (semi >= 0) || c == CH_UPPER_R || c == CH_LOWER_R;
    n     = 0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (note_state)
        ST_DURATION: begin
          if (is_digit) begin
            acc      = int'(note_dur) * 10 + int'(c - CH_ZERO);
            note_dur = (acc > int'(DUR_MAX)) ? DUR_MAX : acc[6:0];
          end else if (starts_pitch) begin
            open_pitch(c, semi[3:0]);
          end else begin
            clear_note();
          end
        end
        ST_PITCH, ST_SHARP: begin
          if (note_state == ST_PITCH && (c == CH_SHARP || c == CH_S)) begin
            // A sharp on E or B is swallowed without changing the pitch.
            if (note_semi != SEMI_E && note_semi != SEMI_B) begin
              note_semi = note_semi + 4'd1;
            end
            note_state = ST_SHARP;
          end else if (is_digit) begin
            note_oct   = c[3:0];
            note_state = ST_OCTAVE;
          end else if (c == CH_DOT) begin
            evs[n] = close_note(1'b1);
            n++;
          end else begin
            evs[n] = close_note(1'b0);
            n++;
            again = 1'b1;
          end
        end
        ST_OCTAVE, ST_REST: begin
          if (c == CH_DOT) begin
            evs[n] = close_note(1'b1);
            n++;
          end else begin
            evs[n] = close_note(1'b0);
            n++;
            again = 1'b1;
          end
        end
        default: begin
          clear_note();
          if (is_digit) begin
            note_dur   = {3'd0, c[3:0]};
            note_state = ST_DURATION;
          end else if (starts_pitch) begin
            open_pitch(c, semi[3:0]);
          end
        end
      endcase
    end
    // End of the argument flushes a pending note and drops pending digits.
    if (req.end_of_text) begin
      if (note_state == ST_PITCH || note_state == ST_SHARP ||
          note_state == ST_OCTAVE || note_state == ST_REST) begin
        evs[n] = close_note(1'b0);
        n++;
      end else begin
        clear_note();
      end
    end
    if (n > 0) begin
      evs[n - 1].last_of_run = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      note_events.push_back(evs[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_char(input logic [7:0] c, input bit eot, input bit drain,
                           input bit idle_ok);
    char_slot_t slot;
    slot.req.char_code   = c;
    slot.req.end_of_text = eot;
    slot.drain           = drain;
    slot.idle_ok         = idle_ok && (pending_chars.size() < CALM_START);
    pending_chars.push_back(slot);
  endtask

  // Queues one whole argument; its last character carries the end flag.
  task automatic push_text(input string s, input bit drain);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], i == s.len() - 1, drain && i == 0, 1'b1);
    end
  endtask

  initial begin
    logic [7:0] tok[$];
    int         seg_end;
    bit         seg_idle;
    bit         seg_drain;
    bit         end_arg;
    bit         first_seg;
    int         ndig;

    rst_n = 1'b0;
    clear_note();

    // Directed part: plain note, saturated duration with a sharp on B and a
    // dot, zero duration on a lowercase rest, sharp on E, digits followed by
    // junk, two events from one character, rest followed by a sharp, rest
    // followed by digits that a space then drops, a character that cannot
    // start a token, the 'S' sharp spelling, and the extreme character codes.
    push_text("C", 1'b0);
    push_text("99B#9.", 1'b0);
    push_text("0r.", 1'b0);
    push_text("E#", 1'b0);
    push_text("2xG", 1'b0);
    push_text("CD", 1'b0);
    push_text("R#", 1'b0);
    push_text("R5 ", 1'b0);
    push_text("aGS0", 1'b0);
    push_char(8'h00, 1'b1, 1'b0, 1'b1);
    push_char(8'hFF, 1'b1, 1'b0, 1'b1);

    // Random part: segments of mostly well-formed tokens with random content,
    // some noise bytes and broken tokens. Each segment either idles or not,
    // and some segments start only after the block has drained.
    first_seg = 1'b1;
    while (pending_chars.size() < TEXT_CHARS) begin
      seg_end   = pending_chars.size() + $urandom_range(40, 250);
      seg_idle  = ($urandom_range(0, 9) < 7);
      seg_drain = first_seg || ($urandom_range(0, 1) == 1);
      first_seg = 1'b0;
      while (pending_chars.size() < seg_end && pending_chars.size() < TEXT_CHARS) begin
        tok.delete();
        if ($urandom_range(0, 99) < 12) begin
          tok.push_back(8'($urandom_range(0, 255)));
          end_arg = 1'($urandom_range(0, 1));
        end else begin
          ndig = $urandom_range(0, 3);
          for (int d = 0; d < ndig; d++) begin
            tok.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          if ($urandom_range(0, 9) == 0) begin
            tok.push_back(8'($urandom_range(0, 255)));
          end else begin
            tok.push_back(pitch_chars[$urandom_range(0, pitch_chars.len() - 1)]);
          end
          if ($urandom_range(0, 2) == 0) begin
            tok.push_back($urandom_range(0, 1) ? CH_SHARP : CH_S);
          end
          if ($urandom_range(0, 1) == 0) begin
            tok.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          if ($urandom_range(0, 3) == 0) begin
            tok.push_back(CH_DOT);
          end
          if ($urandom_range(0, 2) == 0) begin
            tok.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          end
          end_arg = ($urandom_range(0, 3) == 0);
        end
        foreach (tok[k]) begin
          push_char(tok[k], end_arg && k == tok.size() - 1, seg_drain && k == 0, seg_idle);
        end
        seg_drain = 1'b0;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every character has been taken and every event has come out,
    // then let the clock run on so that any stray event shows.
    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (note_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver. A taken character is fed to the predictor at the edge that
  // accepts it; a new one is offered only when the slot frees up.
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_events(in_data);
      end
      if (!in_valid || in_ready) begin
        if (gap_cnt != 0) begin
          gap_cnt  <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && note_events.size() != 0)) begin
          in_valid   <= 1'b1;
          in_data    <= pending_chars[0].req;
          sink_idles <= pending_chars[0].idle_ok;
          // An idle burst, when drawn, follows the character offered now.
          if (pending_chars[0].idle_ok && $urandom_range(0, 5) == 0) begin
            gap_cnt <= $urandom_range(1, 15);
          end
          void'(pending_chars.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Event sink with random stall bursts.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Event monitor: each event taken is compared with the oldest prediction.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    mntp_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (note_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, got %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = note_events.pop_front();
        check_field("is_rest", want.is_rest, out_data.is_rest);
        check_field("semitone", want.semitone, out_data.semitone);
        check_field("octave", want.octave, out_data.octave);
        check_field("duration_denominator", want.duration_denominator,
                    out_data.duration_denominator);
        check_field("dotted", want.dotted, out_data.dotted);
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
      end
    end
  end

  // Watchdog: too long with no request and no event taken ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
